// ===== rtl/ippf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ippf_pkg: shared types and constants of the ipv4 payload pattern filter
// Frame layout offsets, protocol numbers, register indexes and the entry
// that travels from the header parser to the payload matcher.
// ----------------------------------------------------------------------------
package ippf_pkg;

   // default parameter values
   localparam int DEFAULT_MAX_PATTERN_BYTES = 16;
   localparam int DEFAULT_POSITION_BITS     = 16;

   // frame layout
   localparam int ETH_HEADER_BYTES   = 14;
   localparam int IP_PROTO_OFFSET    = 23;
   localparam int TCP_DOFF_OFFSET    = 12;
   localparam int SMALL_HEADER_BYTES = 8;

   // ip protocol numbers
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   // payload start never exceeds 14 + 60 + 60
   localparam int START_BITS = 8;

   // parser to matcher queue, depth a power of two
   localparam int QUEUE_DEPTH = 4;

   // register file
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;
   localparam logic [1:0] REG_PATTERN_LOW  = 2'd0;
   localparam logic [1:0] REG_PATTERN_HIGH = 2'd1;
   localparam logic [1:0] REG_PATTERN_LEN  = 2'd2;

   // result tdata width, fields padded to whole bytes
   localparam int RSP_DATA_BITS = 24;

   typedef enum logic [1:0] {
      CLASS_TCP   = 2'd0,
      CLASS_UDP   = 2'd1,
      CLASS_ICMP  = 2'd2,
      CLASS_OTHER = 2'd3
   } proto_class_type;

   // one classified frame byte
   typedef struct packed {
      logic [7:0]            frame_byte;
      logic                  payload;
      logic                  last;
      proto_class_type       proto_class;
      logic [START_BITS-1:0] payload_start;
      logic                  frame_short;
   } queue_entry_type;

endpackage
`default_nettype wire

// ===== rtl/ippf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ippf_front: header parser
// Counts frame bytes, captures ihl, protocol and tcp data offset, and tags
// each byte as payload or header before it enters the queue.
// ----------------------------------------------------------------------------
module ippf_front #(
   parameter int POSITION_BITS = ippf_pkg::DEFAULT_POSITION_BITS
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire  [7:0]                 req_tdata,   // frame_byte
   input  wire                        req_tlast,   // frame_last
   output logic                       push_valid,
   input  wire                        push_ready,
   output ippf_pkg::queue_entry_type  push_entry
);

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam int SB = ippf_pkg::START_BITS;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [5:0]               ihl_ff, ihl_in;
   logic [7:0]               proto_ff, proto_in;
   logic [6:0]               thb_ff, thb_in;
   logic [6:0]               doff_pos;
   logic [SB-1:0]            start;
   logic [SB-1:0]            gate;
   logic [POSITION_BITS:0]   pos_plus;
   logic                     known;
   logic                     accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid && push_ready;

   // header capture and payload gate
   always_comb begin
      ihl_in   = ihl_ff;
      proto_in = proto_ff;
      thb_in   = thb_ff;
      doff_pos = 7'(ippf_pkg::ETH_HEADER_BYTES + ippf_pkg::TCP_DOFF_OFFSET) + 7'(ihl_ff);
      if (pos_ff == POSITION_BITS'(ippf_pkg::ETH_HEADER_BYTES)) begin
         ihl_in = {req_tdata[3:0], 2'b00};
      end else if (pos_ff == POSITION_BITS'(ippf_pkg::IP_PROTO_OFFSET)) begin
         proto_in = req_tdata;
      end else if (proto_ff == ippf_pkg::PROTO_TCP &&
                   pos_ff > POSITION_BITS'(ippf_pkg::IP_PROTO_OFFSET) &&
                   pos_ff == POSITION_BITS'(doff_pos)) begin
         thb_in = {1'b0, req_tdata[7:4], 2'b00};
      end

      start = SB'(ippf_pkg::ETH_HEADER_BYTES) + SB'(ihl_in) + SB'(thb_in);
      gate  = SB'(ippf_pkg::IP_PROTO_OFFSET + 1);
      if (proto_in == ippf_pkg::PROTO_TCP && (SB'(doff_pos) + SB'(1)) > gate) begin
         gate = SB'(doff_pos) + SB'(1);
      end
      if (start > gate) begin
         gate = start;
      end

      known = (proto_in == ippf_pkg::PROTO_TCP) || (proto_in == ippf_pkg::PROTO_UDP) ||
              (proto_in == ippf_pkg::PROTO_ICMP);

      case (proto_in)
         ippf_pkg::PROTO_TCP:  push_entry.proto_class = ippf_pkg::CLASS_TCP;
         ippf_pkg::PROTO_UDP:  push_entry.proto_class = ippf_pkg::CLASS_UDP;
         ippf_pkg::PROTO_ICMP: push_entry.proto_class = ippf_pkg::CLASS_ICMP;
         default:              push_entry.proto_class = ippf_pkg::CLASS_OTHER;
      endcase

      pos_plus                 = {1'b0, pos_ff} + (POSITION_BITS+1)'(1);
      push_entry.frame_byte    = req_tdata;
      push_entry.payload       = (pos_ff >= POSITION_BITS'(gate)) && known;
      push_entry.last          = req_tlast;
      push_entry.payload_start = start;
      push_entry.frame_short   = pos_plus < (POSITION_BITS+1)'(start);
      pos_in                   = (pos_ff < POS_MAX) ? pos_ff + POSITION_BITS'(1) : pos_ff;
   end

   // per-frame state, cleared after the last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         ihl_ff   <= '0;
         proto_ff <= '0;
         thb_ff   <= 7'(ippf_pkg::SMALL_HEADER_BYTES);
      end else if (accept) begin
         if (req_tlast) begin
            pos_ff   <= '0;
            ihl_ff   <= '0;
            proto_ff <= '0;
            thb_ff   <= 7'(ippf_pkg::SMALL_HEADER_BYTES);
         end else begin
            pos_ff   <= pos_in;
            ihl_ff   <= ihl_in;
            proto_ff <= proto_in;
            thb_ff   <= thb_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ippf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ippf_queue: short queue between parser and matcher
// Holds classified bytes so that either side may stall on its own.
// ----------------------------------------------------------------------------
module ippf_queue (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        push_valid,
   output logic                       push_ready,
   input  ippf_pkg::queue_entry_type  push_entry,
   output logic                       pop_valid,
   input  wire                        pop_ready,
   output ippf_pkg::queue_entry_type  pop_entry
);

   localparam int DEPTH    = ippf_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   ippf_pkg::queue_entry_type entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = count_ff < CNT_BITS'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_entry  = entries_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ippf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ippf_back: payload matcher and result register
// Shifts payload bytes into a window aligned with the pattern, compares all
// bytes in parallel, keeps the sticky found flag and issues the result.
// ----------------------------------------------------------------------------
module ippf_back #(
   parameter int MAX_PATTERN_BYTES = ippf_pkg::DEFAULT_MAX_PATTERN_BYTES
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire  [63:0]                         pattern_low,
   input  wire  [63:0]                         pattern_high,
   input  wire  [4:0]                          pattern_length,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  ippf_pkg::queue_entry_type           in_entry,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // keep_frame, pattern_found, protocol_class[1:0], payload_start[15:0],
   // frame_short, zero pad
   output logic [ippf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam int MAX      = MAX_PATTERN_BYTES;
   localparam int LEN_BITS = $clog2(MAX + 1);

   logic [7:0]          win_ff [MAX];
   logic [7:0]          win_in [MAX];
   logic [7:0]          pat_byte [MAX];
   logic [MAX-1:0]      match_bit;
   logic [LEN_BITS-1:0] len;
   logic [LEN_BITS-1:0] fill_ff, fill_in;
   logic                found_ff, found_now;
   logic                hit;
   logic                pop;

   logic                              rsp_valid_ff;
   logic                              keep_ff, found_out_ff, short_ff;
   ippf_pkg::proto_class_type         class_ff;
   logic [ippf_pkg::START_BITS-1:0]   start_ff;

   // active pattern length, clamped to the window size
   assign len = (pattern_length > 5'(MAX)) ? LEN_BITS'(MAX) : LEN_BITS'(pattern_length);

   // newest byte lands at len-1, older bytes move towards index 0
   for (genvar k = 0; k < MAX; k++) begin : g_win
      if (k == MAX - 1) begin : g_top
         assign win_in[k] = in_entry.frame_byte;
      end else begin : g_mid
         assign win_in[k] = (LEN_BITS'(k + 1) == len) ? in_entry.frame_byte : win_ff[k + 1];
      end
      if (k < 8) begin : g_lo
         assign pat_byte[k] = pattern_low[8*k +: 8];
      end else begin : g_hi
         assign pat_byte[k] = pattern_high[8*(k-8) +: 8];
      end
      assign match_bit[k] = (win_in[k] == pat_byte[k]) || (LEN_BITS'(k) >= len);
   end

   assign fill_in   = (fill_ff < LEN_BITS'(MAX)) ? fill_ff + LEN_BITS'(1) : fill_ff;
   assign hit       = (len != '0) && (fill_in >= len) && (&match_bit);
   assign found_now = found_ff || (in_entry.payload && hit);

   // a last byte waits for the result register, other bytes never stall
   assign in_ready = !in_entry.last || !rsp_valid_ff || rsp_tready;
   assign pop      = in_valid && in_ready;

   // window and sticky flag
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         found_ff <= 1'b0;
      end else if (pop) begin
         if (in_entry.last) begin
            fill_ff  <= '0;
            found_ff <= 1'b0;
         end else if (in_entry.payload) begin
            fill_ff  <= fill_in;
            found_ff <= found_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && in_entry.payload) begin
         win_ff <= win_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop && in_entry.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && in_entry.last) begin
         keep_ff      <= (pattern_length == 5'd0) || found_now;
         found_out_ff <= found_now;
         class_ff     <= in_entry.proto_class;
         start_ff     <= in_entry.payload_start;
         short_ff     <= in_entry.frame_short;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, short_ff, {(16 - ippf_pkg::START_BITS){1'b0}}, start_ff,
                        class_ff, found_out_ff, keep_ff};

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LEN_BITS'(MAX))
      else $error("window fill beyond window size");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (pop && in_entry.last) |=> (fill_ff == '0 && !found_ff))
      else $error("match state not cleared after frame end");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && in_entry.last))
      else $error("result raised without a frame end");

endmodule
`default_nettype wire

// ===== rtl/ipv4_payload_pattern_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_payload_pattern_filter: top level
// Byte-wide ethernet/ipv4 frame filter that searches the transport payload
// for a configured pattern and reports one verdict per frame.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle, back to back, with the
// last byte marked by req_tlast. Each byte is classified by the header parser
// in the cycle it is accepted and passes through a four-entry queue to the
// matcher, which compares the whole pattern window in parallel, so a byte per
// cycle is sustained. With nothing older in the queue, a frame's last byte
// is written into a queue entry and then the result register, which drives
// rsp_tvalid; only a last byte waiting for an untaken result stalls the
// matcher, and req_tready drops once the queue fills up. The pattern
// registers are written over the csr port; the user must write them between
// frames, the block itself does not enforce it.
module ipv4_payload_pattern_filter #(
   parameter int MAX_PATTERN_BYTES = ippf_pkg::DEFAULT_MAX_PATTERN_BYTES,
   parameter int POSITION_BITS     = ippf_pkg::DEFAULT_POSITION_BITS
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // frame byte stream
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [7:0]                          req_tdata,   // frame_byte
   input  wire                                 req_tlast,   // frame_last
   // verdict stream
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // keep_frame, pattern_found, protocol_class[1:0], payload_start[15:0],
   // frame_short, zero pad
   output logic [ippf_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // register port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [ippf_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire  [ippf_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ippf_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [63:0] pattern_low_ff;
   logic [63:0] pattern_high_ff;
   logic [4:0]  pattern_length_ff;
   logic [1:0]  reg_index;
   logic        csr_write;

   ippf_pkg::queue_entry_type push_entry, pop_entry;
   logic push_valid, push_ready, pop_valid, pop_ready;

   // register file, eight bytes per register
   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= '0;
      end else if (csr_write) begin
         case (reg_index)
            ippf_pkg::REG_PATTERN_LOW:  pattern_low_ff    <= csr_pwdata;
            ippf_pkg::REG_PATTERN_HIGH: pattern_high_ff   <= csr_pwdata;
            ippf_pkg::REG_PATTERN_LEN:  pattern_length_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         ippf_pkg::REG_PATTERN_LOW:  csr_prdata = pattern_low_ff;
         ippf_pkg::REG_PATTERN_HIGH: csr_prdata = pattern_high_ff;
         ippf_pkg::REG_PATTERN_LEN:  csr_prdata = {59'd0, pattern_length_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // header parser
   ippf_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // decoupling queue
   ippf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // payload matcher
   ippf_back #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pattern_low    (pattern_low_ff),
      .pattern_high   (pattern_high_ff),
      .pattern_length (pattern_length_ff),
      .in_valid       (pop_valid),
      .in_ready       (pop_ready),
      .in_entry       (pop_entry),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule
`default_nettype wire
